// ===== hdl/utf8_text_sanitizer_assert.svh =====
// Assertion macros shared by the UTF-8 text sanitizer RTL.
// No dependencies; included inside module bodies that assert.
`ifndef UTF8_TEXT_SANITIZER_ASSERT_SVH
`define UTF8_TEXT_SANITIZER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UTXS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8_text_sanitizer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define UTXS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8_text_sanitizer: next-cycle check failed");

`endif

// ===== hdl/utxs_pkg.sv =====
// Shared types and constants of the UTF-8 text sanitizer.
// No dependencies; used by utxs_core and utf8_text_sanitizer.
package utxs_pkg;

   localparam int BufferBytesDefault = 96;
   localparam int MaxResults = 5;
   localparam int CountW = 3;

   localparam logic [7:0] AsciiLimit = 8'h80;
   localparam logic [7:0] CtrlLimit = 8'd32;
   localparam logic [7:0] DelByte = 8'd127;
   localparam logic [7:0] SpaceByte = 8'h20;
   localparam logic [7:0] ContMask = 8'hC0;
   localparam logic [7:0] ContTag = 8'h80;
   localparam logic [7:0] LeadTwoLo = 8'hC2;
   localparam logic [7:0] LeadTwoHi = 8'hDF;
   localparam logic [7:0] LeadThreeLo = 8'hE0;
   localparam logic [7:0] LeadThreeHi = 8'hEF;
   localparam logic [7:0] LeadFourLo = 8'hF0;
   localparam logic [7:0] LeadFourHi = 8'hF4;

   localparam logic [2:0] SeqNone = 3'd0;
   localparam logic [2:0] SeqTwo = 3'd2;
   localparam logic [2:0] SeqThree = 3'd3;
   localparam logic [2:0] SeqFour = 3'd4;

   typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic       repl;
   } utxs_entry_type;

endpackage

// ===== hdl/utxs_core.sv =====
// Decode step of the UTF-8 text sanitizer: sequence state and output budget.
// Depends on utxs_pkg; instantiated by utf8_text_sanitizer.
module utxs_core #(
   parameter int BUFFER_BYTES = utxs_pkg::BufferBytesDefault
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              fire,
   input  logic [7:0]                                        text_byte,
   input  logic                                              end_of_text,
   output utxs_pkg::utxs_entry_type [utxs_pkg::MaxResults-1:0] res_list,
   output logic [utxs_pkg::CountW-1:0]                        res_count
);
   import utxs_pkg::*;

   localparam int WrittenW = $clog2(BUFFER_BYTES);
   localparam int CapW = WrittenW + 1;
   localparam logic [CapW-1:0] Cap = CapW'(BUFFER_BYTES);

   logic [2:0][7:0]        pend_ff, pend_in;
   logic [1:0]             pcount_ff, pcount_in;
   logic [2:0]             elen_ff, elen_in;
   logic [WrittenW-1:0]    written_ff, written_in;
   logic                   stopped_ff, stopped_in;
   utxs_entry_type [MaxResults-1:0] list_in;
   logic [CountW-1:0]      count_in;

   function automatic void emit_one(
      input  logic [7:0]                      b,
      input  logic                            r,
      inout  logic                            st,
      inout  logic [WrittenW-1:0]             bw,
      inout  logic [CountW-1:0]               n,
      inout  utxs_entry_type [MaxResults-1:0] lst
   );
      if (!st) begin
         if (({1'b0, bw} + CapW'(1)) >= Cap) begin
            st = 1'b1;
         end else begin
            lst[n] = {b, 1'b0, r};
            bw = bw + 1'b1;
            n = n + 1'b1;
         end
      end
   endfunction

   function automatic void flush_spaces(
      inout  logic [1:0]                      pc,
      inout  logic [2:0]                      el,
      inout  logic                            st,
      inout  logic [WrittenW-1:0]             bw,
      inout  logic [CountW-1:0]               n,
      inout  utxs_entry_type [MaxResults-1:0] lst
   );
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < pc) begin
            emit_one(SpaceByte, 1'b1, st, bw, n, lst);
         end
      end
      pc = 2'd0;
      el = SeqNone;
   endfunction

   function automatic void take_fresh(
      input  logic [7:0]                      b,
      inout  logic [2:0][7:0]                 pb,
      inout  logic [1:0]                      pc,
      inout  logic [2:0]                      el,
      inout  logic                            st,
      inout  logic [WrittenW-1:0]             bw,
      inout  logic [CountW-1:0]               n,
      inout  utxs_entry_type [MaxResults-1:0] lst
   );
      logic opened;
      opened = 1'b0;
      if (b < AsciiLimit) begin
         if (b < CtrlLimit || b == DelByte) begin
            emit_one(SpaceByte, 1'b1, st, bw, n, lst);
         end else begin
            emit_one(b, 1'b0, st, bw, n, lst);
         end
      end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
         el = SeqTwo;
         opened = 1'b1;
      end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
         el = SeqThree;
         opened = 1'b1;
      end else if (b >= LeadFourLo && b <= LeadFourHi) begin
         el = SeqFour;
         opened = 1'b1;
      end else begin
         emit_one(SpaceByte, 1'b1, st, bw, n, lst);
      end
      if (opened) begin
         pb[0] = b;
         pc = 2'd1;
      end
   endfunction

   always_comb begin
      pend_in = pend_ff;
      pcount_in = pcount_ff;
      elen_in = elen_ff;
      written_in = written_ff;
      stopped_in = stopped_ff;
      list_in = '0;
      count_in = '0;
      if (!stopped_in) begin
         if (pcount_in == 2'd0) begin
            take_fresh(text_byte, pend_in, pcount_in, elen_in, stopped_in, written_in,
                       count_in, list_in);
         end else if ((text_byte & ContMask) != ContTag) begin
            flush_spaces(pcount_in, elen_in, stopped_in, written_in, count_in, list_in);
            take_fresh(text_byte, pend_in, pcount_in, elen_in, stopped_in, written_in,
                       count_in, list_in);
         end else if (({1'b0, pcount_in} + 3'd1) >= elen_in) begin
            if (({1'b0, written_in} + CapW'(elen_in)) >= Cap) begin
               stopped_in = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < pcount_in) begin
                     list_in[count_in] = {pend_in[i], 1'b0, 1'b0};
                     written_in = written_in + 1'b1;
                     count_in = count_in + 1'b1;
                  end
               end
               list_in[count_in] = {text_byte, 1'b0, 1'b0};
               written_in = written_in + 1'b1;
               count_in = count_in + 1'b1;
            end
            pcount_in = 2'd0;
            elen_in = SeqNone;
         end else if (pcount_in < 2'd3) begin
            pend_in[pcount_in] = text_byte;
            pcount_in = pcount_in + 2'd1;
         end
      end
      if (end_of_text) begin
         flush_spaces(pcount_in, elen_in, stopped_in, written_in, count_in, list_in);
         list_in[count_in] = {8'h00, 1'b1, 1'b0};
         count_in = count_in + 1'b1;
         written_in = '0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= 2'd0;
         elen_ff <= SeqNone;
         written_ff <= '0;
         stopped_ff <= 1'b0;
      end else if (fire) begin
         pcount_ff <= pcount_in;
         elen_ff <= elen_in;
         written_ff <= written_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_ff <= pend_in;
      end
   end

   assign res_list = list_in;
   assign res_count = count_in;

endmodule

// ===== hdl/utf8_text_sanitizer.sv =====
// UTF-8 text sanitizer, top level: input register, step unit, result list.
// Depends on utxs_pkg, utxs_core and utf8_text_sanitizer_assert.svh.
//
// Takes one text byte per item and gives the cleaned bytes, then a terminator at
// end of text. An item is registered at the input, decoded by the step unit into
// a list of zero to five results, and that list is sent out one result per cycle
// while rsp_ready is high. Items that give at most one result flow at one item
// per cycle under the same condition, through the input register and the
// result-list register; an item that gives k results holds the result list
// until all k are taken, as the single result port drains one result a cycle.
// BUFFER_BYTES sets the output capacity per text, including the terminator.
module utf8_text_sanitizer #(
   parameter int BUFFER_BYTES = utxs_pkg::BufferBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_terminator,
   output logic       rsp_was_replaced,
   output logic       rsp_last_of_run
);
   import utxs_pkg::*;

   logic                            in_valid_ff;
   logic [7:0]                      in_byte_ff;
   logic                            in_eot_ff;
   utxs_entry_type [MaxResults-1:0] list_ff;
   logic [CountW-1:0]               cnt_ff;
   logic [CountW-1:0]               idx_ff;
   utxs_entry_type [MaxResults-1:0] step_list;
   logic [CountW-1:0]               step_count;
   logic                            out_busy;
   logic                            out_last;
   logic                            out_done;
   logic                            process;
   utxs_entry_type                  cur_entry;

   utxs_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (process),
      .text_byte  (in_byte_ff),
      .end_of_text(in_eot_ff),
      .res_list   (step_list),
      .res_count  (step_count)
   );

   assign out_busy = (idx_ff != cnt_ff);
   assign out_last = (idx_ff == (cnt_ff - 1'b1));
   assign out_done = out_busy && rsp_ready && out_last;
   assign process = in_valid_ff && (!out_busy || out_done);
   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (process) begin
         cnt_ff <= step_count;
         idx_ff <= '0;
      end else if (out_busy && rsp_ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         list_ff <= step_list;
      end
   end

   assign cur_entry = list_ff[idx_ff];
   assign rsp_valid = out_busy;
   assign rsp_out_byte = cur_entry.data;
   assign rsp_is_terminator = cur_entry.term;
   assign rsp_was_replaced = cur_entry.repl;
   assign rsp_last_of_run = out_last;

`include "utf8_text_sanitizer_assert.svh"

   `UTXS_ASSERT_SAME(a_idx_in_range, clock, reset, 1'b1, idx_ff <= cnt_ff)
   `UTXS_ASSERT_SAME(a_cnt_bounded, clock, reset, 1'b1, cnt_ff <= CountW'(MaxResults))
   `UTXS_ASSERT_SAME(a_term_is_last, clock, reset, rsp_valid && rsp_is_terminator,
                     rsp_last_of_run)
   `UTXS_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run,
                     rsp_valid)

endmodule
